// ----- rtl/core/vrfc_pkg.sv -----
// Shared types and constants for the voxel row face culler.
// Used by the face output queue and the top level; no dependencies.
package vrfc_pkg;

   localparam int COL_W       = 5;
   localparam int MAT_W       = 16;
   localparam int COORD_W     = 16;
   localparam int FACE_W      = 3;
   localparam int KIND_W      = 2;
   localparam int NB_W        = 2;
   localparam int NUM_NB      = 4;
   localparam int CNT_W       = 6;
   localparam int MAX_RESULTS = 34;
   localparam int REQ_TDATA_W = 64;
   localparam int RSP_TDATA_W = 64;

   // input item kinds
   localparam logic [KIND_W-1:0] KIND_ROW_START = 2'd0;
   localparam logic [KIND_W-1:0] KIND_NB_SEG    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_CENTRE    = 2'd2;

   // face codes
   localparam logic [FACE_W-1:0] FACE_LEFT  = 3'd0;
   localparam logic [FACE_W-1:0] FACE_RIGHT = 3'd1;
   localparam logic [FACE_W-1:0] FACE_TOP   = 3'd2;

   typedef struct packed {
      logic [FACE_W-1:0]  face;
      logic [COL_W-1:0]   col;
      logic [COL_W-1:0]   width;
      logic [COORD_W-1:0] coord_y;
      logic [COORD_W-1:0] coord_z;
      logic [MAT_W-1:0]   mat;
   } face_type;

   typedef struct packed {
      logic push;
      logic flush;
   } qctl_type;

endpackage

// ----- rtl/core/vrfc_face_queue.sv -----
// Face output queue: one pending face plus the output register.
// The pending face is held back so the final face of an item can be tagged last.
// Depends on vrfc_pkg.
module vrfc_face_queue
   import vrfc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  qctl_type               ctl,
   input  face_type               face,
   output logic                   q_ready,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // face, column_start, face_width, coord_y, coord_z, face_material, zero fill
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   output logic                   rsp_tlast
);

   logic     pend_vld_ff, pend_vld_in;
   face_type pend_ff, pend_in;
   logic     out_vld_ff, out_vld_in;
   face_type out_ff, out_in;
   logic     out_last_ff, out_last_in;

   assign q_ready = !out_vld_ff || rsp_tready;

   always_comb begin
      pend_vld_in = pend_vld_ff;
      pend_in     = pend_ff;
      out_vld_in  = out_vld_ff && !rsp_tready;
      out_in      = out_ff;
      out_last_in = out_last_ff;
      if (ctl.push && q_ready) begin
         if (pend_vld_ff) begin
            out_vld_in  = 1'b1;
            out_in      = pend_ff;
            out_last_in = 1'b0;
         end
         pend_in     = face;
         pend_vld_in = 1'b1;
      end else if (ctl.flush && q_ready && pend_vld_ff) begin
         out_vld_in  = 1'b1;
         out_in      = pend_ff;
         out_last_in = 1'b1;
         pend_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_vld_ff <= 1'b0;
         out_vld_ff  <= 1'b0;
      end else begin
         pend_vld_ff <= pend_vld_in;
         out_vld_ff  <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff     <= pend_in;
      out_ff      <= out_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = {3'b000, out_ff.mat, out_ff.coord_z, out_ff.coord_y,
                        out_ff.width, out_ff.col, out_ff.face};

`ifndef SYNTHESIS
   a_no_push_flush: assert property (@(posedge clock) disable iff (reset)
      !(ctl.push && ctl.flush))
      else $error("push and flush together");

   a_flush_marks_last: assert property (@(posedge clock) disable iff (reset)
      ctl.flush && q_ready && pend_vld_ff |=> rsp_tvalid && rsp_tlast)
      else $error("flushed face not shown as last beat");

   a_push_keeps_pending: assert property (@(posedge clock) disable iff (reset)
      ctl.push && q_ready |=> pend_vld_ff)
      else $error("pushed face lost");
`endif

endmodule

// ----- rtl/core/voxel_row_face_culler.sv -----
// Voxel row face culler top level: row state, neighbour air masks, column scan sequencer.
// Depends on vrfc_pkg and vrfc_face_queue.
//
// Usage: req_ carries one item per beat; req_tuser selects row start, neighbour segment
// or centre segment. A row start clears the four neighbour air masks and latches the
// row coordinates; neighbour segments fill the masks; centre segments produce faces.
// rsp_ carries one face per beat, rsp_tlast marking the final face of the item.
// Row start, neighbour segments and ignored items give no beats. An air centre segment
// gives at most one beat. For a solid centre segment, one column scanner walks the
// segment once per neighbour row (top, bottom, front, back), and a side or run face is
// queued as it is found. At most 34 beats per item. A face is held in the pending
// register so tlast can be set; the last beat of an item reaches rsp_ in the cycle
// req_tready rises again.
// req_tready is high only between items; the last beat of an item may still wait in the
// output register while the next item is taken. A stalled receiver stops the scanner.
// Reset (synchronous, active high) clears masks, row state and both channels.
module voxel_row_face_culler
   import vrfc_pkg::*;
#(
   parameter int ROW_WIDTH = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // row_y, row_z, left_is_air, right_is_air, neighbour, run_length, material, zero fill
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // kind
   input  logic [KIND_W-1:0]      req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // face, column_start, face_width, coord_y, coord_z, face_material, zero fill
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   output logic                   rsp_tlast
);

   localparam int IDX_W = (ROW_WIDTH > 1) ? $clog2(ROW_WIDTH) : 1;
   localparam logic [COL_W-1:0] RW_COL = COL_W'(ROW_WIDTH);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_RIGHT = 3'd1;
   localparam logic [2:0] S_LEFT  = 3'd2;
   localparam logic [2:0] S_SCAN  = 3'd3;
   localparam logic [2:0] S_FLUSH = 3'd4;

   // input fields
   logic [KIND_W-1:0]  in_kind;
   logic [COORD_W-1:0] in_row_y, in_row_z;
   logic               in_left_air, in_right_air;
   logic [NB_W-1:0]    in_nb;
   logic [COL_W-1:0]   in_run;
   logic [MAT_W-1:0]   in_mat;

   assign in_kind      = req_tuser;
   assign in_row_y     = req_tdata[15:0];
   assign in_row_z     = req_tdata[31:16];
   assign in_left_air  = req_tdata[32];
   assign in_right_air = req_tdata[33];
   assign in_nb        = req_tdata[35:34];
   assign in_run       = req_tdata[40:36];
   assign in_mat       = req_tdata[56:41];

   // row state
   logic [ROW_WIDTH-1:0] air_ff [NUM_NB];
   logic [ROW_WIDTH-1:0] air_in [NUM_NB];
   logic [COL_W-1:0]     fill_ff [NUM_NB];
   logic [COL_W-1:0]     fill_in [NUM_NB];
   logic [COL_W-1:0]     centre_pos_ff, centre_pos_in;
   logic                 in_air_ff, in_air_in;
   logic [MAT_W-1:0]     prev_mat_ff, prev_mat_in;
   logic [COORD_W-1:0]   coord_y_ff, coord_y_in;
   logic [COORD_W-1:0]   coord_z_ff, coord_z_in;
   logic                 right_air_ff, right_air_in;

   // sequencer
   logic [2:0]       state_ff, state_in;
   logic [COL_W-1:0] seg_start_ff, seg_start_in;
   logic [COL_W-1:0] seg_stop_ff, seg_stop_in;
   logic [MAT_W-1:0] face_mat_ff, face_mat_in;
   logic             do_right_ff, do_right_in;
   logic [COL_W-1:0] right_col_ff, right_col_in;
   logic             do_left_ff, do_left_in;
   logic             do_scan_ff, do_scan_in;
   logic [NB_W-1:0]  nb_ff, nb_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic             open_ff, open_in;
   logic [COL_W-1:0] run_start_ff, run_start_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   logic             accept;
   logic [COL_W-1:0] span_start, span_stop;
   logic [COL_W:0]   span_sum;
   logic [ROW_WIDTH-1:0] span;
   logic             cur_bit;
   logic             cap_hit;
   qctl_type         qctl;
   face_type         qface;
   logic             q_ready;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;

   // one adder serves both neighbour fill and centre position
   assign span_start = (in_kind == KIND_NB_SEG) ? fill_ff[in_nb] : centre_pos_ff;
   assign span_sum   = {1'b0, span_start} + {1'b0, in_run};
   assign span_stop  = (span_sum > {1'b0, RW_COL}) ? RW_COL : span_sum[COL_W-1:0];

   always_comb begin
      for (int i = 0; i < ROW_WIDTH; i++) begin
         span[i] = (COL_W'(i) >= span_start) && (COL_W'(i) < span_stop);
      end
   end

   assign cur_bit = air_ff[nb_ff][col_ff[IDX_W-1:0]];
   assign cap_hit = (cnt_ff + 1'b1) == CNT_W'(MAX_RESULTS);

   always_comb begin
      air_in        = air_ff;
      fill_in       = fill_ff;
      centre_pos_in = centre_pos_ff;
      in_air_in     = in_air_ff;
      prev_mat_in   = prev_mat_ff;
      coord_y_in    = coord_y_ff;
      coord_z_in    = coord_z_ff;
      right_air_in  = right_air_ff;
      state_in      = state_ff;
      seg_start_in  = seg_start_ff;
      seg_stop_in   = seg_stop_ff;
      face_mat_in   = face_mat_ff;
      do_right_in   = do_right_ff;
      right_col_in  = right_col_ff;
      do_left_in    = do_left_ff;
      do_scan_in    = do_scan_ff;
      nb_in         = nb_ff;
      col_in        = col_ff;
      open_in       = open_ff;
      run_start_in  = run_start_ff;
      cnt_in        = cnt_ff;
      qctl          = '0;
      qface.face    = FACE_TOP + FACE_W'(nb_ff);
      qface.col     = run_start_ff;
      qface.width   = col_ff - run_start_ff;
      qface.coord_y = coord_y_ff;
      qface.coord_z = coord_z_ff;
      qface.mat     = face_mat_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (in_kind)
                  KIND_ROW_START: begin
                     for (int n = 0; n < NUM_NB; n++) begin
                        air_in[n]  = '0;
                        fill_in[n] = '0;
                     end
                     centre_pos_in = '0;
                     prev_mat_in   = '0;
                     coord_y_in    = in_row_y;
                     coord_z_in    = in_row_z;
                     in_air_in     = in_left_air;
                     right_air_in  = in_right_air;
                  end
                  KIND_NB_SEG: begin
                     if (span_start < RW_COL) begin
                        if (in_mat == '0) air_in[in_nb] = air_ff[in_nb] | span;
                        fill_in[in_nb] = span_stop;
                     end
                  end
                  KIND_CENTRE: begin
                     if (span_start < RW_COL) begin
                        centre_pos_in = span_stop;
                        seg_start_in  = span_start;
                        seg_stop_in   = span_stop;
                        nb_in         = '0;
                        col_in        = span_start;
                        open_in       = 1'b0;
                        cnt_in        = '0;
                        prev_mat_in   = in_mat;
                        state_in      = S_RIGHT;
                        if (in_mat == '0) begin
                           // solid-to-air boundary belongs to the previous segment
                           do_right_in  = !in_air_ff && (span_start != '0);
                           right_col_in = span_start;
                           face_mat_in  = prev_mat_ff;
                           do_left_in   = 1'b0;
                           do_scan_in   = 1'b0;
                           in_air_in    = 1'b1;
                        end else begin
                           do_right_in  = (span_stop == RW_COL) && right_air_ff;
                           right_col_in = RW_COL;
                           face_mat_in  = in_mat;
                           do_left_in   = in_air_ff;
                           do_scan_in   = 1'b1;
                           in_air_in    = 1'b0;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_RIGHT: begin
            qface.face  = FACE_RIGHT;
            qface.col   = right_col_ff;
            qface.width = COL_W'(1);
            if (!do_right_ff) begin
               state_in = S_LEFT;
            end else if (q_ready) begin
               qctl.push = 1'b1;
               cnt_in    = cnt_ff + 1'b1;
               state_in  = S_LEFT;
            end
         end
         S_LEFT: begin
            qface.face  = FACE_LEFT;
            qface.col   = seg_start_ff;
            qface.width = COL_W'(1);
            if (!do_left_ff) begin
               state_in = do_scan_ff ? S_SCAN : S_FLUSH;
            end else if (q_ready) begin
               qctl.push = 1'b1;
               cnt_in    = cnt_ff + 1'b1;
               state_in  = do_scan_ff ? S_SCAN : S_FLUSH;
            end
         end
         S_SCAN: begin
            if (q_ready) begin
               if (col_ff != seg_stop_ff) begin
                  col_in = col_ff + 1'b1;
                  if (cur_bit && !open_ff) begin
                     open_in      = 1'b1;
                     run_start_in = col_ff;
                  end else if (!cur_bit && open_ff) begin
                     qctl.push = 1'b1;
                     open_in   = 1'b0;
                     cnt_in    = cnt_ff + 1'b1;
                     if (cap_hit) state_in = S_FLUSH;
                  end
               end else begin
                  // segment end: close an open run, move to the next neighbour row
                  col_in  = seg_start_ff;
                  nb_in   = nb_ff + 1'b1;
                  open_in = 1'b0;
                  if (nb_ff == NB_W'(NUM_NB - 1)) state_in = S_FLUSH;
                  if (open_ff) begin
                     qctl.push = 1'b1;
                     cnt_in    = cnt_ff + 1'b1;
                     if (cap_hit) state_in = S_FLUSH;
                  end
               end
            end
         end
         S_FLUSH: begin
            if (q_ready) begin
               qctl.flush = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int n = 0; n < NUM_NB; n++) begin
            air_ff[n]  <= '0;
            fill_ff[n] <= '0;
         end
         centre_pos_ff <= '0;
         in_air_ff     <= 1'b0;
         prev_mat_ff   <= '0;
         coord_y_ff    <= '0;
         coord_z_ff    <= '0;
         right_air_ff  <= 1'b0;
         state_ff      <= S_IDLE;
         cnt_ff        <= '0;
         open_ff       <= 1'b0;
         nb_ff         <= '0;
         col_ff        <= '0;
      end else begin
         air_ff        <= air_in;
         fill_ff       <= fill_in;
         centre_pos_ff <= centre_pos_in;
         in_air_ff     <= in_air_in;
         prev_mat_ff   <= prev_mat_in;
         coord_y_ff    <= coord_y_in;
         coord_z_ff    <= coord_z_in;
         right_air_ff  <= right_air_in;
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         open_ff       <= open_in;
         nb_ff         <= nb_in;
         col_ff        <= col_in;
      end
   end

   always_ff @(posedge clock) begin
      seg_start_ff <= seg_start_in;
      seg_stop_ff  <= seg_stop_in;
      face_mat_ff  <= face_mat_in;
      do_right_ff  <= do_right_in;
      right_col_ff <= right_col_in;
      do_left_ff   <= do_left_in;
      do_scan_ff   <= do_scan_in;
      run_start_ff <= run_start_in;
   end

   vrfc_face_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .ctl        (qctl),
      .face       (qface),
      .q_ready    (q_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
